FILE: hdl/phm_pkg.sv
package phm_pkg;
    localparam int BUCKET_COUNT = 4096;
    localparam int NODE_COUNT   = 256;
    localparam int KEY_BITS     = 32;
    localparam int VALUE_BITS   = 32;
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int PTR_W  = NODE_W + 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_LOOKUP     = 2'd2,
        REQ_NONE       = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_POOL_FULL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HEAD_RD, S_HEAD_WAIT, S_NODE_RD, S_NODE_WAIT,
        S_CHECK, S_FREE_RD, S_FREE_WAIT, S_WRITE, S_UNLINK, S_DONE
    } t_state;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_BITS-1:0] key);
        logic [KEY_BITS:0] s;
        s = {1'b0, key >> 8} + {{(KEY_BITS-7){1'b0}}, key[7:0]};
        return s[BKT_W-1:0];
    endfunction
endpackage

FILE: hdl/port_name_hash_map.sv
// port name hash map: chained hash table of 32-bit names to 32-bit values
// s_axis: one request per transfer; tdata = {entry_value, port_name, req_type}
//   req_type 0 register, 1 unregister, 2 lookup, 3 no operation
// m_axis: one result per request; tdata = {found_value, status}
// a request walks the chain of its bucket: the bucket head is read, then for each
//   chain node the node memory is read and its key compared with the name
//   register of a new name then reads the free list and writes the new node,
//   unregister of a present name then unlinks the node from its chain
// one request in flight at a time; each chain node step is a node memory read
//   and a key compare
// with a ready receiver the next request can be taken in the cycle after the result
//   transfer; the block is already back in idle while the result is shown
// after reset a clearing pass writes every bucket head empty and builds the
//   free list, with s_axis_tready low
// the result sits in an output register; a stalled receiver holds it and
//   the block takes no new request until it has been transferred
// heads, keys, values and links live in synchronous memories with a registered read
module port_name_hash_map
    import phm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // req_type[1:0], port_name[33:2], entry_value[65:34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status[1:0], found_value[33:2]
);
    t_state r_state, n_state;
    logic [BKT_W-1:0]      r_cnt;
    t_req                  r_req;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [BKT_W-1:0]      r_bkt;
    logic [PTR_W-1:0]      r_cur, r_prev, r_free, r_hit_next;
    logic [PTR_W:0]        r_steps;
    logic [1:0]            r_status;
    logic [VALUE_BITS-1:0] r_found;
    logic                  r_out_v;

    // memories
    logic              h_we;  logic [BKT_W-1:0] h_wa, h_ra; logic [PTR_W-1:0] h_wd, h_rd;
    logic              k_we;  logic [NODE_W-1:0] n_ra, k_wa;
    logic [KEY_BITS-1:0] k_rd; logic [VALUE_BITS-1:0] d_rd;
    logic              l_we;  logic [NODE_W-1:0] l_wa; logic [PTR_W-1:0] l_wd, l_rd;

    phm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKET_COUNT)) u_head (
        .i_clk, .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd), .i_raddr(h_ra), .o_rdata(h_rd));
    phm_ram #(.WIDTH(KEY_BITS), .DEPTH(NODE_COUNT)) u_key (
        .i_clk, .i_we(k_we), .i_waddr(k_wa), .i_wdata(r_key), .i_raddr(n_ra), .o_rdata(k_rd));
    phm_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODE_COUNT)) u_data (
        .i_clk, .i_we(k_we), .i_waddr(k_wa), .i_wdata(r_val), .i_raddr(n_ra), .o_rdata(d_rd));
    phm_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_link (
        .i_clk, .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd), .i_raddr(n_ra), .o_rdata(l_rd));

    logic s_fire, m_fire, hit, at_end;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_out_v;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {6'd0, r_found, r_status};
    assign hit    = (k_rd == r_key);
    assign at_end = (r_cur == NIL) || (r_steps == (PTR_W+1)'(NODE_COUNT));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_cnt == BKT_W'(BUCKET_COUNT-1)) n_state = S_IDLE;
            S_IDLE:      if (s_fire) n_state = S_HEAD_RD;
            S_HEAD_RD:   n_state = S_HEAD_WAIT;
            S_HEAD_WAIT: n_state = S_NODE_RD;
            S_NODE_RD:   n_state = at_end ? S_CHECK : S_NODE_WAIT;
            S_NODE_WAIT: n_state = S_CHECK;
            S_CHECK: begin
                if (!at_end && !hit) n_state = S_NODE_RD;
                else if (r_req == REQ_REGISTER && at_end && r_free != NIL) n_state = S_FREE_RD;
                else if (r_req == REQ_UNREGISTER && !at_end) n_state = S_UNLINK;
                else n_state = S_DONE;
            end
            S_FREE_RD:   n_state = S_FREE_WAIT;
            S_FREE_WAIT: n_state = S_WRITE;
            S_WRITE:     n_state = S_DONE;
            S_UNLINK:    n_state = S_DONE;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        h_we = 1'b0; h_wa = r_bkt; h_wd = NIL; h_ra = r_bkt;
        k_we = 1'b0; k_wa = r_cur[NODE_W-1:0];
        l_we = 1'b0; l_wa = r_cnt[NODE_W-1:0]; l_wd = NIL;
        n_ra = r_cur[NODE_W-1:0];
        unique case (r_state)
            S_CLEAR: begin
                h_we = 1'b1; h_wa = r_cnt;
                if (r_cnt < BKT_W'(NODE_COUNT)) begin
                    l_we = 1'b1;
                    l_wd = PTR_W'(r_cnt) + PTR_W'(1);
                end
            end
            S_FREE_RD: n_ra = r_free[NODE_W-1:0];
            S_WRITE: begin
                // r_cur holds the node just taken from the free list
                k_we = 1'b1;
                l_we = 1'b1; l_wa = r_cur[NODE_W-1:0]; l_wd = NIL;
            end
            S_DONE: begin
                // tail link or bucket head for register, or hit link to free head for unregister
                if (r_req == REQ_REGISTER && r_status == ST_OK && r_prev != NIL) begin
                    l_we = 1'b1; l_wa = r_prev[NODE_W-1:0]; l_wd = r_cur;
                end else if (r_req == REQ_UNREGISTER && r_status == ST_OK) begin
                    l_we = 1'b1; l_wa = r_cur[NODE_W-1:0]; l_wd = r_free;
                end
                if (r_req == REQ_REGISTER && r_status == ST_OK && r_prev == NIL) begin
                    h_we = 1'b1; h_wd = r_cur;
                end
            end
            S_UNLINK: begin
                if (r_prev != NIL) begin
                    l_we = 1'b1; l_wa = r_prev[NODE_W-1:0]; l_wd = r_hit_next;
                end else begin
                    h_we = 1'b1; h_wd = r_hit_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_free  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) r_out_v <= 1'b1;
            else if (m_fire) r_out_v <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_cnt <= r_cnt + BKT_W'(1);
                S_IDLE: if (s_fire) begin
                    r_req    <= t_req'(s_axis_tdata[1:0]);
                    r_key    <= s_axis_tdata[33:2];
                    r_val    <= s_axis_tdata[65:34];
                    r_bkt    <= bucket_of(s_axis_tdata[33:2]);
                    r_prev   <= NIL;
                    r_steps  <= '0;
                    r_status <= ST_OK;
                    r_found  <= '0;
                end
                S_HEAD_WAIT: r_cur <= (r_req == REQ_NONE) ? NIL : h_rd;
                S_CHECK: begin
                    if (!at_end && !hit) begin
                        r_prev  <= r_cur;
                        r_cur   <= l_rd;
                        r_steps <= r_steps + (PTR_W+1)'(1);
                    end else if (!at_end) begin
                        r_hit_next <= l_rd;
                        if (r_req == REQ_REGISTER) r_status <= ST_DUPLICATE;
                        if (r_req == REQ_LOOKUP) r_found <= d_rd;
                    end else begin
                        if (r_req == REQ_REGISTER && r_free == NIL) r_status <= ST_POOL_FULL;
                        if (r_req == REQ_UNREGISTER || r_req == REQ_LOOKUP)
                            r_status <= ST_NOT_FOUND;
                    end
                end
                S_FREE_WAIT: begin
                    r_cur  <= r_free;
                    r_free <= l_rd;
                end
                S_DONE: begin
                    if (r_req == REQ_UNREGISTER && r_status == ST_OK) r_free <= r_cur;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !m_axis_tvalid) else $error("result present at accept");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> m_axis_tdata[33:2] == '0)
        else $error("value on failed request");
`endif
endmodule

FILE: hdl/phm_ram.sv
module phm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: verif/port_name_hash_map_tb.sv
module port_name_hash_map_tb;
    import phm_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // req_type[1:0], port_name[33:2], entry_value[65:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status[1:0], found_value[33:2]

    port_name_hash_map u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // one request of the map
    typedef struct packed {
        logic [31:0] entry_value;
        logic [31:0] port_name;
        t_req        req_type;
    } t_request;

    // one expected result
    typedef struct packed {
        logic [31:0] found_value;
        t_status     status;
    } t_result;

    // directed row: request plus an optional hand-typed answer
    typedef struct {
        t_request req;
        bit       typed;
        t_result  answer;
    } t_row;

    // shadow copy of the map state
    logic [PTR_W-1:0] shadow_head [BUCKET_COUNT];
    logic [31:0]      shadow_key  [NODE_COUNT];
    logic [31:0]      shadow_data [NODE_COUNT];
    logic [PTR_W-1:0] shadow_link [NODE_COUNT];
    logic [PTR_W-1:0] shadow_free;

    t_result pending_results[$];
    t_row    directed_rows[$];
    logic [31:0] live_names[$];   // names currently registered, for well-formed traffic
    int  error_count;
    int  recv_count;
    bit  hold_receiver;           // long receiver stall requested by the sender process

    always #5 i_clk = ~i_clk;

    // hard time limit: several times the clear pass plus all items at full-pool
    // chains and the longest stalls
    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, recv_count);
        error_count++;
    endtask

    function automatic logic [BKT_W-1:0] hash_bucket(input logic [31:0] name);
        logic [32:0] s;
        s = {1'b0, name >> 8} + {25'd0, name[7:0]};
        return s[BKT_W-1:0];
    endfunction

    function automatic void map_reset();
        for (int i = 0; i < BUCKET_COUNT; i++) shadow_head[i] = NIL;
        for (int i = 0; i < NODE_COUNT; i++) begin
            shadow_key[i]  = '0;
            shadow_data[i] = '0;
            shadow_link[i] = PTR_W'(i + 1);
        end
        shadow_free = '0;
        live_names.delete();
    endfunction

    // chain search: returns matching node or NIL, prev gets the node before it
    function automatic logic [PTR_W-1:0] chain_find(input logic [BKT_W-1:0] b,
            input logic [31:0] name, output logic [PTR_W-1:0] prev);
        logic [PTR_W-1:0] cur;
        int steps;
        cur = shadow_head[b];
        prev = NIL;
        steps = 0;
        while (cur < NIL && steps < NODE_COUNT) begin
            if (shadow_key[cur[NODE_W-1:0]] == name) return cur;
            prev = cur;
            cur = shadow_link[cur[NODE_W-1:0]];
            steps++;
        end
        return NIL;
    endfunction

    function automatic t_result map_apply(input t_request r);
        t_result res;
        logic [BKT_W-1:0] b;
        logic [PTR_W-1:0] hit, prev, n;
        res = '{found_value: '0, status: ST_OK};
        b = hash_bucket(r.port_name);
        case (r.req_type)
            REQ_REGISTER: begin
                hit = chain_find(b, r.port_name, prev);
                if (hit < NIL) res.status = ST_DUPLICATE;
                else if (shadow_free >= NIL) res.status = ST_POOL_FULL;
                else begin
                    n = shadow_free;
                    shadow_free = shadow_link[n[NODE_W-1:0]];
                    shadow_key[n[NODE_W-1:0]]  = r.port_name;
                    shadow_data[n[NODE_W-1:0]] = r.entry_value;
                    shadow_link[n[NODE_W-1:0]] = NIL;
                    if (prev < NIL) shadow_link[prev[NODE_W-1:0]] = n;
                    else shadow_head[b] = n;
                    live_names.push_back(r.port_name);
                end
            end
            REQ_UNREGISTER: begin
                hit = chain_find(b, r.port_name, prev);
                if (hit >= NIL) res.status = ST_NOT_FOUND;
                else begin
                    if (prev < NIL) shadow_link[prev[NODE_W-1:0]] = shadow_link[hit[NODE_W-1:0]];
                    else shadow_head[b] = shadow_link[hit[NODE_W-1:0]];
                    shadow_link[hit[NODE_W-1:0]] = shadow_free;
                    shadow_free = hit;
                    foreach (live_names[i])
                        if (live_names[i] == r.port_name) begin
                            live_names.delete(i);
                            break;
                        end
                end
            end
            REQ_LOOKUP: begin
                hit = chain_find(b, r.port_name, prev);
                if (hit >= NIL) res.status = ST_NOT_FOUND;
                else res.found_value = shadow_data[hit[NODE_W-1:0]];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_row make_row(input t_req k, input logic [31:0] name,
            input logic [31:0] value, input bit typed = 0,
            input t_status st = ST_OK, input logic [31:0] fv = '0);
        t_row row;
        row.req    = '{entry_value: value, port_name: name, req_type: k};
        row.typed  = typed;
        row.answer = '{found_value: fv, status: st};
        return row;
    endfunction

    // send one request: given gap, then hold valid until the transfer;
    // valid stays up after the transfer so back to back requests need no gap
    task automatic send_request(input t_request r, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // request accepted at this edge; predict now so order matches results
        pending_results.push_back(map_apply(r));
    endtask

    task automatic send_row(input t_row row, input int gap);
        t_result predicted;
        send_request(row.req, gap);
        predicted = pending_results[$];
        if (row.typed && predicted != row.answer)
            report_mismatch("typed row", {30'd0, predicted.status}, {30'd0, row.answer.status});
    endtask

    function automatic t_request random_request();
        t_request r;
        int pick;
        pick = $urandom_range(0, 99);
        r.entry_value = $urandom();
        // names mostly from a small colliding set so chains grow and hits happen
        if (pick < 10) r.port_name = $urandom();
        else if (pick < 45 && live_names.size() > 0)
            r.port_name = live_names[$urandom_range(0, live_names.size() - 1)];
        else r.port_name = {6'd0, 2'($urandom_range(0, 3)), 4'd0,
                            12'($urandom_range(0, 15)), 8'($urandom_range(0, 7))};
        pick = $urandom_range(0, 99);
        if (pick < 40) r.req_type = REQ_REGISTER;
        else if (pick < 65) r.req_type = REQ_UNREGISTER;
        else if (pick < 97) r.req_type = REQ_LOOKUP;
        else r.req_type = REQ_NONE;
        return r;
    endfunction

    // receiver: random wait per result, long hold-off on request, checks every transfer
    initial begin
        t_result got, want;
        int wait_cycles;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_receiver) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_receiver = 0;
            end else begin
                wait_cycles = $urandom_range(0, 15);
                if (wait_cycles > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got = m_axis_tdata[33:0];
            recv_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", got.found_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", {30'd0, got.status}, {30'd0, want.status});
                if (got.found_value !== want.found_value)
                    report_mismatch("found_value", got.found_value, want.found_value);
            end
        end
    end

    // sender and run control
    initial begin
        t_request r;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        error_count = 0;
        recv_count = 0;
        hold_receiver = 0;
        map_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: extremes, each request kind, not-found and duplicate status
        directed_rows.push_back(make_row(REQ_LOOKUP, 32'h0, 32'h0, 1, ST_NOT_FOUND, 0));
        directed_rows.push_back(make_row(REQ_UNREGISTER, 32'hffff_ffff, 0, 1, ST_NOT_FOUND, 0));
        directed_rows.push_back(make_row(REQ_REGISTER, 32'h0, 32'hffff_ffff, 1, ST_OK, 0));
        directed_rows.push_back(make_row(REQ_REGISTER, 32'hffff_ffff, 32'h0, 1, ST_OK, 0));
        directed_rows.push_back(make_row(REQ_REGISTER, 32'h0, 32'h1234, 1, ST_DUPLICATE, 0));
        directed_rows.push_back(make_row(REQ_LOOKUP, 32'h0, 32'h5555, 1, ST_OK, 32'hffff_ffff));
        directed_rows.push_back(make_row(REQ_LOOKUP, 32'hffff_ffff, 0, 1, ST_OK, 0));
        // same bucket: 0x100, 0x001 and 0x100001 all hash to bucket 1, chain of three
        directed_rows.push_back(make_row(REQ_REGISTER, 32'h0000_0100, 32'haaaa_5555));
        directed_rows.push_back(make_row(REQ_REGISTER, 32'h0000_0001, 32'h5555_aaaa));
        directed_rows.push_back(make_row(REQ_REGISTER, 32'h0010_0001, 32'h0f0f_f0f0));
        directed_rows.push_back(make_row(REQ_UNREGISTER, 32'h0000_0001, 0));
        directed_rows.push_back(make_row(REQ_LOOKUP, 32'h0010_0001, 0));
        directed_rows.push_back(make_row(REQ_UNREGISTER, 32'h0000_0100, 0));
        directed_rows.push_back(make_row(REQ_LOOKUP, 32'h0000_0001, 0, 1, ST_NOT_FOUND, 0));
        directed_rows.push_back(make_row(REQ_NONE, 32'hdead_beef, 32'hffff_ffff, 1, ST_OK, 0));
        directed_rows.push_back(make_row(REQ_UNREGISTER, 32'h0, 0, 1, ST_OK, 0));
        directed_rows.push_back(make_row(REQ_LOOKUP, 32'haaaa_aaaa, 32'h5555_5555,
                                         1, ST_NOT_FOUND, 0));
        foreach (directed_rows[i]) send_row(directed_rows[i], $urandom_range(0, 15));

        // fill the pool to the last node, then overflow: pool-full status
        while (shadow_free < NIL) begin
            r = '{entry_value: $urandom(), port_name: $urandom(), req_type: REQ_REGISTER};
            send_request(r, (shadow_free[3:0] == 0) ? $urandom_range(0, 15) : 0);
        end
        send_row(make_row(REQ_REGISTER, 32'h5a5a_5a5a, 1, 1, ST_POOL_FULL, 0), 0);
        send_row(make_row(REQ_LOOKUP, live_names[0], 0), 0);
        // drain most entries again
        while (live_names.size() > 20) begin
            r = '{entry_value: $urandom(), port_name: live_names[$urandom_range(0,
                  live_names.size() - 1)], req_type: REQ_UNREGISTER};
            send_request(r, 0);
        end

        // receiver holds off while requests keep coming in back to back
        hold_receiver = 1;
        repeat (40) send_request(random_request(), 0);

        // sender pauses until every expected result has come
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        for (int i = 0; i < 1500; i++) begin
            // stretches with no idling alternate with random gaps
            send_request(random_request(), ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 15));
        end

        // wait for the tail, then run on before the verdict
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

FILE: port_name_hash_map.f
hdl/phm_pkg.sv
hdl/phm_ram.sv
hdl/port_name_hash_map.sv
verif/port_name_hash_map_tb.sv
